// ----- rtl/hee_pkg.sv -----
// Package for the HTML escaper: command types, character codes and string helpers.
package hee_pkg;

  // Width of run counts; holds run lengths up to 63
  localparam int CNT_W = 6;

  // Register indexes (paddr[2])
  localparam logic REG_KEEP_REFS = 1'b0;
  localparam logic REG_ESC_HIGH  = 1'b1;

  // Character codes
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // How a held run is resolved
  typedef enum logic [1:0] {
    RES_NONE,
    RES_KEEP,
    RES_NOTREF
  } hee_res_e;

  // Expansion of the byte itself
  typedef enum logic [2:0] {
    PL_NONE,
    PL_LIT,
    PL_QUOT,
    PL_LT,
    PL_GT,
    PL_AMP,
    PL_NUM
  } hee_plain_e;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    B_IDLE,
    B_PRE,
    B_HADDR,
    B_HDATA,
    B_POST,
    B_PLAIN
  } hee_back_state_e;

  // One classified input transaction
  typedef struct packed {
    logic [7:0]       text_byte;
    logic             text_end;
    logic             hold;
    logic [CNT_W-1:0] wr_idx;
    hee_res_e         res;
    logic [CNT_W-1:0] held_n;
    hee_plain_e       plain;
  } hee_cmd_t;

  // Number of bytes an expansion emits
  function automatic logic [2:0] plain_len(hee_plain_e p);
    logic [2:0] len;
    case (p)
      PL_LIT:             len = 3'd1;
      PL_QUOT, PL_NUM:    len = 3'd6;
      PL_LT, PL_GT:       len = 3'd4;
      PL_AMP:             len = 3'd5;
      default:            len = 3'd0;
    endcase
    return len;
  endfunction

  // Decimal digit of a byte: pos 0 hundreds, 1 tens, 2 ones
  function automatic logic [7:0] dec_digit(logic [7:0] c, logic [1:0] pos);
    logic [1:0]  h;
    logic [6:0]  r;
    logic [14:0] p;
    logic [3:0]  t;
    logic [3:0]  o;
    logic [7:0]  d;
    h = (c >= 8'd200) ? 2'd2 : ((c >= 8'd100) ? 2'd1 : 2'd0);
    r = 7'(c - (8'(h) * 8'd100));
    // r / 10 by reciprocal, exact for r below 100
    p = 15'(r) * 15'd205;
    t = 4'(p >> 11);
    o = 4'(r - (7'(t) * 7'd10));
    case (pos)
      2'd0:    d = CH_ZERO + 8'(h);
      2'd1:    d = CH_ZERO + 8'(t);
      default: d = CH_ZERO + 8'(o);
    endcase
    return d;
  endfunction

  // Byte k of an expansion of byte c
  function automatic logic [7:0] plain_char(hee_plain_e p, logic [2:0] k, logic [7:0] c);
    logic [7:0] ch;
    ch = CH_SEMI;
    case (p)
      PL_LIT: ch = c;
      PL_QUOT: begin
        case (k)
          3'd0:    ch = CH_AMP;
          3'd1:    ch = 8'h71;
          3'd2:    ch = 8'h75;
          3'd3:    ch = 8'h6f;
          3'd4:    ch = 8'h74;
          default: ch = CH_SEMI;
        endcase
      end
      PL_LT, PL_GT: begin
        case (k)
          3'd0:    ch = CH_AMP;
          3'd1:    ch = (p == PL_LT) ? 8'h6c : 8'h67;
          3'd2:    ch = 8'h74;
          default: ch = CH_SEMI;
        endcase
      end
      PL_AMP: begin
        case (k)
          3'd0:    ch = CH_AMP;
          3'd1:    ch = 8'h61;
          3'd2:    ch = 8'h6d;
          3'd3:    ch = 8'h70;
          default: ch = CH_SEMI;
        endcase
      end
      PL_NUM: begin
        case (k)
          3'd0:    ch = CH_AMP;
          3'd1:    ch = CH_HASH;
          3'd2:    ch = dec_digit(c, 2'd0);
          3'd3:    ch = dec_digit(c, 2'd1);
          3'd4:    ch = dec_digit(c, 2'd2);
          default: ch = CH_SEMI;
        endcase
      end
      default: ch = CH_SEMI;
    endcase
    return ch;
  endfunction

endpackage

// ----- rtl/hee_if.sv -----
// Stream interfaces for the text input and the escaped output.
interface hee_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       text_end;

  modport source (output valid, output text_byte, output text_end, input ready);
  modport sink   (input valid, input text_byte, input text_end, output ready);
endinterface

interface hee_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       text_done;

  modport source (output valid, output out_byte, output run_last, output text_done,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input text_done,
                  output ready);
endinterface

// ----- rtl/hee_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module hee_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/hee_front.sv -----
// Front end: accepts text bytes, tracks held ampersand runs and emits commands.
module hee_front
  import hee_pkg::*;
#(
  parameter int MAX_REF_LEN = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hee_in_if.sink     text_i,
  input  logic       keep_refs_i,
  input  logic       esc_high_i,
  input  logic       full_i,
  output logic       push_o,
  output hee_cmd_t   cmd_o
);

  logic             pend_q, pend_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             is_run;
  logic             run_fits;
  logic             start_amp;
  hee_plain_e       plain_k;
  logic [7:0]       c;

  assign c            = text_i.text_byte;
  assign text_i.ready = !full_i;
  assign push_o       = text_i.valid && !full_i;

  // Byte classes
  always_comb begin
    is_run = ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5a)) ||
             ((c >= 8'h61) && (c <= 8'h7a)) || (c == CH_HASH);
    run_fits  = (cnt_q < CNT_W'(MAX_REF_LEN));
    start_amp = 1'b0;
    if (c[7] && esc_high_i) begin
      plain_k = PL_NUM;
    end else if (c == CH_QUOTE) begin
      plain_k = PL_QUOT;
    end else if (c == CH_LT) begin
      plain_k = PL_LT;
    end else if (c == CH_GT) begin
      plain_k = PL_GT;
    end else if (c == CH_AMP) begin
      if (keep_refs_i && !text_i.text_end) begin
        plain_k   = PL_NONE;
        start_amp = 1'b1;
      end else begin
        plain_k = PL_AMP;
      end
    end else begin
      plain_k = PL_LIT;
    end
  end

  // Command build and run tracking
  always_comb begin
    cmd_o.text_byte = c;
    cmd_o.text_end  = text_i.text_end;
    cmd_o.hold      = 1'b0;
    cmd_o.wr_idx    = cnt_q;
    cmd_o.res       = RES_NONE;
    cmd_o.held_n    = cnt_q;
    cmd_o.plain     = PL_NONE;
    pend_d          = pend_q;
    cnt_d           = cnt_q;
    if (pend_q) begin
      if (c == CH_SEMI) begin
        cmd_o.res = RES_KEEP;
        pend_d    = 1'b0;
        cnt_d     = '0;
      end else if (is_run && run_fits) begin
        cmd_o.hold = 1'b1;
        cnt_d      = cnt_q + CNT_W'(1);
        if (text_i.text_end) begin
          cmd_o.res    = RES_NOTREF;
          cmd_o.held_n = cnt_q + CNT_W'(1);
        end
      end else begin
        cmd_o.res   = RES_NOTREF;
        cmd_o.plain = plain_k;
        pend_d      = start_amp;
        cnt_d       = '0;
      end
    end else begin
      cmd_o.plain = plain_k;
      pend_d      = start_amp;
      cnt_d       = '0;
    end
    if (text_i.text_end) begin
      pend_d = 1'b0;
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      cnt_q  <= '0;
    end else if (push_o) begin
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ----- rtl/hee_cmd_fifo.sv -----
// Two-entry command queue between the front and back ends.
module hee_cmd_fifo
  import hee_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  hee_cmd_t cmd_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output hee_cmd_t cmd_o
);

  hee_cmd_t   entry_q [2];
  logic       wptr_q;
  logic       rptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign cmd_o   = entry_q[rptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= cmd_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ----- rtl/hee_back.sv -----
// Back end: runs commands, buffers run bytes in RAM and emits escaped bytes.
module hee_back
  import hee_pkg::*;
#(
  parameter int MAX_REF_LEN = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  hee_cmd_t cmd_i,
  output logic     pop_o,
  hee_out_if.source esc_o
);

  localparam int IDX_W = (MAX_REF_LEN > 1) ? $clog2(MAX_REF_LEN) : 1;

  hee_back_state_e  state_q, state_d;
  logic [CNT_W-1:0] k_q, k_d;
  hee_cmd_t         cmd_q;

  logic             ov_q;
  logic [7:0]       ob_q;
  logic             olast_q;
  logic             odone_q;

  logic             can_load;
  logic             phase_end;
  hee_back_state_e  after_pre, after_held, after_post, start_st, nxt_st;
  logic             emit_valid;
  logic [7:0]       emit_byte;
  logic             emit_last;
  logic [7:0]       rd_data;
  logic             we;

  assign can_load = !ov_q || esc_o.ready;

  // Run-byte buffer
  assign we = pop_o && cmd_i.hold;

  hee_ram #(
    .WIDTH (8),
    .DEPTH (MAX_REF_LEN)
  ) u_held_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cmd_i.wr_idx[IDX_W-1:0]),
    .wdata_i (cmd_i.text_byte),
    .raddr_i (k_q[IDX_W-1:0]),
    .rdata_o (rd_data)
  );

  // Phase sequencing shared by both blocks
  always_comb begin
    after_post = (cmd_q.plain != PL_NONE) ? B_PLAIN : B_IDLE;
    after_held = (cmd_q.res == RES_KEEP) ? B_POST : after_post;
    after_pre  = (cmd_q.held_n != '0) ? B_HADDR : after_held;
    if (cmd_i.res != RES_NONE) begin
      start_st = B_PRE;
    end else if (cmd_i.plain != PL_NONE) begin
      start_st = B_PLAIN;
    end else begin
      start_st = B_IDLE;
    end
    phase_end = 1'b0;
    nxt_st    = B_IDLE;
    case (state_q)
      B_PRE: begin
        phase_end = (cmd_q.res == RES_KEEP) ? 1'b1 : (k_q == CNT_W'(4));
        nxt_st    = after_pre;
      end
      B_HDATA: begin
        phase_end = ((k_q + CNT_W'(1)) == cmd_q.held_n);
        nxt_st    = after_held;
      end
      B_POST: begin
        phase_end = 1'b1;
        nxt_st    = after_post;
      end
      B_PLAIN: begin
        phase_end = ((k_q[2:0] + 3'd1) == plain_len(cmd_q.plain));
        nxt_st    = B_IDLE;
      end
      default: begin
        phase_end = 1'b0;
        nxt_st    = B_IDLE;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    unique case (state_q)
      B_IDLE: begin
        if (valid_i) begin
          state_d = start_st;
          k_d     = '0;
        end
      end
      B_HADDR: begin
        state_d = B_HDATA;
      end
      B_PRE, B_POST, B_PLAIN: begin
        if (can_load) begin
          if (phase_end) begin
            state_d = nxt_st;
            k_d     = '0;
          end else begin
            k_d = k_q + CNT_W'(1);
          end
        end
      end
      B_HDATA: begin
        if (can_load) begin
          if (phase_end) begin
            state_d = nxt_st;
            k_d     = '0;
          end else begin
            state_d = B_HADDR;
            k_d     = k_q + CNT_W'(1);
          end
        end
      end
      default: begin
        state_d = B_IDLE;
        k_d     = '0;
      end
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    pop_o      = 1'b0;
    emit_valid = 1'b0;
    emit_byte  = CH_SEMI;
    unique case (state_q)
      B_IDLE: begin
        pop_o = valid_i;
      end
      B_PRE: begin
        emit_valid = 1'b1;
        emit_byte  = (cmd_q.res == RES_KEEP) ? CH_AMP :
                     plain_char(PL_AMP, k_q[2:0], cmd_q.text_byte);
      end
      B_HADDR: begin
        emit_valid = 1'b0;
      end
      B_HDATA: begin
        emit_valid = 1'b1;
        emit_byte  = rd_data;
      end
      B_POST: begin
        emit_valid = 1'b1;
        emit_byte  = CH_SEMI;
      end
      B_PLAIN: begin
        emit_valid = 1'b1;
        emit_byte  = plain_char(cmd_q.plain, k_q[2:0], cmd_q.text_byte);
      end
      default: begin
        emit_valid = 1'b0;
      end
    endcase
    emit_last = phase_end && (nxt_st == B_IDLE);
  end

  // Sequencer and command registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= cmd_i;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (can_load) begin
      ov_q <= emit_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_load && emit_valid) begin
      ob_q    <= emit_byte;
      olast_q <= emit_last;
      odone_q <= emit_last && cmd_q.text_end;
    end
  end

  assign esc_o.valid     = ov_q;
  assign esc_o.out_byte  = ob_q;
  assign esc_o.run_last  = olast_q;
  assign esc_o.text_done = odone_q;

endmodule

// ----- rtl/html_escape_keeping_entity_refs_unit.sv -----
// Top level of the HTML escaper that keeps semicolon-ended entity references.
//
// text_i carries one text byte per transaction with an end-of-text mark;
// esc_o carries the escaped bytes, one per transaction, with run_last on the
// last byte caused by an input byte and text_done on the last byte of a text.
// The APB port holds keep_entity_refs at address 0 and escape_high_bytes at
// address 4; write them only while the block is idle.
// A front end classifies each byte and queues one command per byte in a
// two-entry queue; the back end expands commands into bytes.
// The back end takes one command at a time, each in its idle state, and
// then emits one byte per cycle while the receiver does not stall, except
// bytes flushed from the run buffer, which pass through an address state and
// a data state for the registered RAM read.
// A held run byte causes no result.
// Reset clears the run tracking, the queue and the output register and sets
// both mode registers to 1; the run buffer RAM is not cleared.
// When the receiver stalls, the output register holds its byte, the back end
// waits, the queue fills and text_i.ready drops.
module html_escape_keeping_entity_refs_unit
  import hee_pkg::*;
#(
  parameter int MAX_REF_LEN = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hee_in_if.sink      text_i,
  hee_out_if.source   esc_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic     keep_refs_q;
  logic     esc_high_q;
  logic     full;
  logic     push;
  logic     pop;
  logic     q_valid;
  hee_cmd_t front_cmd;
  hee_cmd_t q_cmd;

  // Configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_refs_q <= 1'b1;
      esc_high_q  <= 1'b1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_KEEP_REFS: keep_refs_q <= pwdata[0];
        REG_ESC_HIGH:  esc_high_q  <= pwdata[0];
        default:       keep_refs_q <= keep_refs_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_KEEP_REFS: prdata = {31'd0, keep_refs_q};
      REG_ESC_HIGH:  prdata = {31'd0, esc_high_q};
      default:       prdata = 32'd0;
    endcase
  end

  // Front end
  hee_front #(
    .MAX_REF_LEN (MAX_REF_LEN)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .text_i      (text_i),
    .keep_refs_i (keep_refs_q),
    .esc_high_i  (esc_high_q),
    .full_i      (full),
    .push_o      (push),
    .cmd_o       (front_cmd)
  );

  // Command queue
  hee_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  // Back end
  hee_back #(
    .MAX_REF_LEN (MAX_REF_LEN)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .cmd_i   (q_cmd),
    .pop_o   (pop),
    .esc_o   (esc_o)
  );

endmodule
